[src/etla_pkg.sv]
// Shared constants and elaboration-time tables for the look-angle pipeline.
// Holds the CORDIC arctangent table, the gain correction and register indexes.
// Used by etla_cordic and ecef_to_look_angles.
package etla_pkg;

    localparam int NIT = 62;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STATION_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_LAT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_LON = 3'd4;

    // pi in Q60 and 1/pi in Q64
    localparam logic signed [63:0] PI_Q60     = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] HALF_PI_Q60 = PI_Q60 >>> 1;
    localparam logic [63:0]        INV_PI_Q64 = 64'h517CC1B727220A95;

    // atan(2^-i) in Q60 by power series with truncating division
    function automatic logic [63:0] atab_f(input int i);
        logic [63:0] t;
        logic [63:0] term;
        int k;
        t = '0;
        if (i == 0) begin
            t = 64'(PI_Q60 >>> 2);
        end else begin
            for (k = 0; i * (2 * k + 1) <= 60; k++) begin
                term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
                t = (k % 2 == 1) ? t - term : t + term;
            end
        end
        return t;
    endfunction

    // Gain correction floor(2^123 / G), G measured by vectoring (2^61, 0)
    function automatic logic [63:0] gain_k_f();
        logic signed [63:0] gx;
        logic signed [63:0] gy;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic [63:0] d;
        logic [63:0] r;
        logic [63:0] q;
        int i;
        int b;
        gx = 64'sh2000000000000000;
        gy = '0;
        for (i = 0; i < NIT; i++) begin
            xs = gx >>> i;
            ys = gy >>> i;
            if (gy < 0) begin
                gx = gx - ys;
                gy = gy + xs;
            end else begin
                gx = gx + ys;
                gy = gy - xs;
            end
        end
        d = 64'(gx);
        r = '0;
        q = '0;
        for (b = 123; b >= 0; b--) begin
            r = (r << 1) | ((b == 123) ? 64'd1 : 64'd0);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    localparam logic [63:0] GAIN_K = gain_k_f();

endpackage

[src/etla_mulsh.sv]
// Signed-by-unsigned constant multiply with round-half-away shift, two stages.
// Four 32x32 partial products, then a 128-bit sum and shift.
module etla_mulsh #(
    parameter int SHIFT  = 62,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [63:0]  i_v,
    input  logic [63:0]         i_k,
    input  logic [SIDE_W-1:0]   i_side,
    output logic signed [63:0]  o_v,
    output logic [SIDE_W-1:0]   o_side
);

    logic [63:0]        mag;
    logic               r_neg;
    logic [63:0]        r_p00, r_p01, r_p10, r_p11;
    logic [SIDE_W-1:0]  r_side1;
    logic [127:0]       full;
    logic [127:0]       shf;
    logic signed [63:0] n_v;
    logic signed [63:0] r_v;
    logic [SIDE_W-1:0]  r_side2;

    assign mag = i_v[63] ? 64'(-i_v) : 64'(i_v);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg   <= i_v[63];
            r_p00   <= 64'(mag[31:0])  * 64'(i_k[31:0]);
            r_p01   <= 64'(mag[31:0])  * 64'(i_k[63:32]);
            r_p10   <= 64'(mag[63:32]) * 64'(i_k[31:0]);
            r_p11   <= 64'(mag[63:32]) * 64'(i_k[63:32]);
            r_side1 <= i_side;
        end
    end

    always_comb begin
        full = 128'(r_p00) + (128'(r_p01) << 32) + (128'(r_p10) << 32)
             + (128'(r_p11) << 64) + (128'd1 << (SHIFT - 1));
        shf  = full >> SHIFT;
        n_v  = r_neg ? -signed'(shf[63:0]) : signed'(shf[63:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v     <= n_v;
            r_side2 <= r_side1;
        end
    end

    assign o_v    = r_v;
    assign o_side = r_side2;

endmodule

[src/etla_cordic.sv]
// Fully unrolled CORDIC, one iteration per register stage, rotating or vectoring.
// The quadrant fold is registered ahead of the iterations. Uses etla_pkg tables.
module etla_cordic #(
    parameter bit VEC    = 1'b0,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_z,
    input  logic [SIDE_W-1:0]  i_side,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic signed [63:0] o_z,
    output logic [SIDE_W-1:0]  o_side
);

    logic signed [63:0] r_x [0:etla_pkg::NIT];
    logic signed [63:0] r_y [0:etla_pkg::NIT];
    logic signed [63:0] r_z [0:etla_pkg::NIT];
    logic [SIDE_W-1:0]  r_s [0:etla_pkg::NIT];
    logic signed [63:0] n_x0, n_y0, n_z0;

    // fold into the right half plane / into +-pi/2
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = i_z;
        if (VEC) begin
            n_z0 = '0;
            if (i_x < 0) begin
                n_z0 = (i_y >= 0) ? etla_pkg::PI_Q60 : -etla_pkg::PI_Q60;
                n_x0 = -i_x;
                n_y0 = -i_y;
            end
        end else begin
            if (i_z > etla_pkg::HALF_PI_Q60) begin
                n_z0 = i_z - etla_pkg::PI_Q60;
                n_x0 = -i_x;
                n_y0 = -i_y;
            end else if (i_z < -etla_pkg::HALF_PI_Q60) begin
                n_z0 = i_z + etla_pkg::PI_Q60;
                n_x0 = -i_x;
                n_y0 = -i_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
            r_s[0] <= i_side;
        end
    end

    for (genvar g = 0; g < etla_pkg::NIT; g++) begin : g_iter
        localparam logic signed [63:0] ATAN = signed'(etla_pkg::atab_f(g));
        logic signed [63:0] xs, ys;
        logic               ccw;

        always_comb begin
            xs  = r_x[g] >>> g;
            ys  = r_y[g] >>> g;
            ccw = VEC ? (r_y[g] < 0) : (r_z[g] >= 0);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[g+1] <= r_s[g];
                if (ccw) begin
                    r_x[g+1] <= r_x[g] - ys;
                    r_y[g+1] <= r_y[g] + xs;
                    r_z[g+1] <= VEC ? r_z[g] - ATAN : r_z[g] - ATAN;
                end else begin
                    r_x[g+1] <= r_x[g] + ys;
                    r_y[g+1] <= r_y[g] - xs;
                    r_z[g+1] <= r_z[g] + ATAN;
                end
            end
        end
    end

    assign o_x    = r_x[etla_pkg::NIT];
    assign o_y    = r_y[etla_pkg::NIT];
    assign o_z    = r_z[etla_pkg::NIT];
    assign o_side = r_s[etla_pkg::NIT];

endmodule

[src/ecef_to_look_angles.sv]
// Earth-centered satellite position to slant range, azimuth and elevation.
// Uses etla_pkg, etla_cordic (four CORDIC pipelines) and etla_mulsh.
//
// Input stream: one request per satellite position (sat_x, sat_y, sat_z).
// Output stream: one result per request, in order: slant range, azimuth and
// elevation in tdata, the coincident-point flag in tuser.
// Config channel: station x, y, z, latitude, longitude by register index;
// always ready. Write it only while no request is in flight.
// The path runs through two entry stages, four 63-stage CORDIC pipelines,
// five two-stage gain or angle multipliers in series and the output register.
// Throughput is one request per cycle while the receiver takes results; each
// CORDIC iteration has its own register stage.
// Reset clears the station registers and all valid bits; no result is shown
// until a request is accepted.
// When the receiver stalls the whole pipeline holds in place, with the result
// in the output register, and the input ready drops until the result is taken.
module ecef_to_look_angles #(
    parameter int COORD_BITS = 38,
    parameter int ANGLE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sat_x, sat_y, sat_z
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((3*(COORD_BITS-1)+7)/8)*8-1:0] i_s_tdata,
    // slant_range, azimuth, elevation
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [((COORD_BITS-1+2*ANGLE_BITS+7)/8)*8-1:0] o_m_tdata,
    // zero_range
    output logic [0:0]                          o_m_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [etla_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [((COORD_BITS-1) > ANGLE_BITS ? COORD_BITS-1 : ANGLE_BITS)-1:0] i_cfg_data
);

    localparam int CW    = COORD_BITS - 1;
    localparam int AB    = ANGLE_BITS;
    localparam int GUARD = 61 - COORD_BITS;
    localparam int OTW   = ((CW + 2 * AB + 7) / 8) * 8;
    localparam int LAT   = 265;

    logic signed [CW-1:0] r_st_x, r_st_y, r_st_z;
    logic signed [AB-1:0] r_st_lat, r_st_lon;
    logic signed [63:0]   lat_q, lon_q;

    logic                 en, acc;
    logic [LAT-1:0]       r_vld;

    logic signed [CW:0]   r_dx, r_dy, r_dz;
    logic signed [63:0]   r_x0, r_y0, r_q0;
    logic                 r_zero0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_x   <= '0;
            r_st_y   <= '0;
            r_st_z   <= '0;
            r_st_lat <= '0;
            r_st_lon <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                etla_pkg::REG_STATION_X:   r_st_x   <= i_cfg_data[CW-1:0];
                etla_pkg::REG_STATION_Y:   r_st_y   <= i_cfg_data[CW-1:0];
                etla_pkg::REG_STATION_Z:   r_st_z   <= i_cfg_data[CW-1:0];
                etla_pkg::REG_STATION_LAT: r_st_lat <= i_cfg_data[AB-1:0];
                etla_pkg::REG_STATION_LON: r_st_lon <= i_cfg_data[AB-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // station angles to Q60 radians
    etla_mulsh #(.SHIFT(AB - 1), .SIDE_W(1)) u_lat (
        .i_clk(i_clk), .i_en(1'b1), .i_v(64'(r_st_lat)),
        .i_k(64'(etla_pkg::PI_Q60)), .i_side(1'b0), .o_v(lat_q), .o_side()
    );
    etla_mulsh #(.SHIFT(AB - 1), .SIDE_W(1)) u_lon (
        .i_clk(i_clk), .i_en(1'b1), .i_v(64'(r_st_lon)),
        .i_k(64'(etla_pkg::PI_Q60)), .i_side(1'b0), .o_v(lon_q), .o_side()
    );

    assign en         = ~r_vld[LAT-1] | i_m_tready;
    assign o_s_tready = en;
    assign acc        = i_s_tvalid & en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], acc};
        end
    end

    // difference to station, then scale and flag coincidence
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx    <= (CW+1)'(signed'(i_s_tdata[CW-1:0]))      - (CW+1)'(r_st_x);
            r_dy    <= (CW+1)'(signed'(i_s_tdata[2*CW-1:CW]))   - (CW+1)'(r_st_y);
            r_dz    <= (CW+1)'(signed'(i_s_tdata[3*CW-1:2*CW])) - (CW+1)'(r_st_z);
            r_x0    <= 64'(r_dx) <<< GUARD;
            r_y0    <= 64'(r_dy) <<< GUARD;
            r_q0    <= 64'(r_dz) <<< GUARD;
            r_zero0 <= (r_dx == '0) && (r_dy == '0) && (r_dz == '0);
        end
    end

    logic signed [63:0] rot1_x, rot1_y, p1, east1, rot2_x, rot2_y, up2, north2;
    logic signed [63:0] v1_x, v1_z, p3, v2_x, v2_z, r4, az5, el5;
    logic [64:0]        s_rot1, s_mA, s_rot2, s_mB, s_v1, s_v2;
    logic [128:0]       s_mC, s_mD, s_mE;

    // rotate by -lon about z
    etla_cordic #(.VEC(1'b0), .SIDE_W(65)) u_rot_lon (
        .i_clk(i_clk), .i_en(en), .i_x(r_x0), .i_y(r_y0), .i_z(-lon_q),
        .i_side({r_q0, r_zero0}), .o_x(rot1_x), .o_y(rot1_y), .o_z(),
        .o_side(s_rot1)
    );
    etla_mulsh #(.SHIFT(62), .SIDE_W(65)) u_gain_p (
        .i_clk(i_clk), .i_en(en), .i_v(rot1_x), .i_k(etla_pkg::GAIN_K),
        .i_side(s_rot1), .o_v(p1), .o_side(s_mA)
    );
    etla_mulsh #(.SHIFT(62), .SIDE_W(1)) u_gain_east (
        .i_clk(i_clk), .i_en(en), .i_v(rot1_y), .i_k(etla_pkg::GAIN_K),
        .i_side(1'b0), .o_v(east1), .o_side()
    );

    // rotate by -lat in the (p, z) plane
    etla_cordic #(.VEC(1'b0), .SIDE_W(65)) u_rot_lat (
        .i_clk(i_clk), .i_en(en), .i_x(p1), .i_y(s_mA[64:1]), .i_z(-lat_q),
        .i_side({east1, s_mA[0]}), .o_x(rot2_x), .o_y(rot2_y), .o_z(),
        .o_side(s_rot2)
    );
    etla_mulsh #(.SHIFT(62), .SIDE_W(65)) u_gain_up (
        .i_clk(i_clk), .i_en(en), .i_v(rot2_x), .i_k(etla_pkg::GAIN_K),
        .i_side(s_rot2), .o_v(up2), .o_side(s_mB)
    );
    etla_mulsh #(.SHIFT(62), .SIDE_W(1)) u_gain_north (
        .i_clk(i_clk), .i_en(en), .i_v(rot2_y), .i_k(etla_pkg::GAIN_K),
        .i_side(1'b0), .o_v(north2), .o_side()
    );

    // azimuth = atan2(east, north)
    etla_cordic #(.VEC(1'b1), .SIDE_W(65)) u_vec_az (
        .i_clk(i_clk), .i_en(en), .i_x(north2), .i_y(s_mB[64:1]), .i_z(64'sd0),
        .i_side({up2, s_mB[0]}), .o_x(v1_x), .o_y(), .o_z(v1_z),
        .o_side(s_v1)
    );
    etla_mulsh #(.SHIFT(62), .SIDE_W(129)) u_gain_h (
        .i_clk(i_clk), .i_en(en), .i_v(v1_x), .i_k(etla_pkg::GAIN_K),
        .i_side({v1_z, s_v1}), .o_v(p3), .o_side(s_mC)
    );

    // elevation = atan2(up, horizontal)
    etla_cordic #(.VEC(1'b1), .SIDE_W(65)) u_vec_el (
        .i_clk(i_clk), .i_en(en), .i_x(p3), .i_y(s_mC[64:1]), .i_z(64'sd0),
        .i_side({s_mC[128:65], s_mC[0]}), .o_x(v2_x), .o_y(), .o_z(v2_z),
        .o_side(s_v2)
    );
    etla_mulsh #(.SHIFT(62), .SIDE_W(129)) u_gain_r (
        .i_clk(i_clk), .i_en(en), .i_v(v2_x), .i_k(etla_pkg::GAIN_K),
        .i_side({v2_z, s_v2}), .o_v(r4), .o_side(s_mD)
    );

    // radians to binary angle
    etla_mulsh #(.SHIFT(125 - AB), .SIDE_W(129)) u_bin_az (
        .i_clk(i_clk), .i_en(en), .i_v(s_mD[64:1]), .i_k(etla_pkg::INV_PI_Q64),
        .i_side({r4, s_mD[128:65], s_mD[0]}), .o_v(az5), .o_side(s_mE)
    );
    etla_mulsh #(.SHIFT(125 - AB), .SIDE_W(1)) u_bin_el (
        .i_clk(i_clk), .i_en(en), .i_v(s_mD[128:65]), .i_k(etla_pkg::INV_PI_Q64),
        .i_side(1'b0), .o_v(el5), .o_side()
    );

    logic [63:0]    rsum, rsh;
    logic [CW-1:0]  n_rng;
    logic [CW-1:0]  r_rng;
    logic [AB-1:0]  r_az, r_el;
    logic           r_zero;

    always_comb begin
        rsum  = 64'(s_mE[128:65]) + (64'd1 << (GUARD - 1));
        rsh   = rsum >> GUARD;
        n_rng = (rsh > 64'({CW{1'b1}})) ? {CW{1'b1}} : rsh[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero <= s_mE[0];
            r_rng  <= s_mE[0] ? '0 : n_rng;
            r_az   <= s_mE[0] ? '0 : az5[AB-1:0];
            r_el   <= s_mE[0] ? '0 : el5[AB-1:0];
        end
    end

    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = OTW'({r_el, r_az, r_rng});
    assign o_m_tuser  = r_zero;

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("coincident result carries nonzero range or angles");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input held off without an output stall");

endmodule
